[rtl/core/qtg_pkg.sv]
package qtg_pkg;

  localparam int unsigned ROM_FRAC    = 20;
  localparam int unsigned ROM_W       = ROM_FRAC + 1;   // holds 0 .. 2^20
  localparam int unsigned AMP_W       = 16;
  localparam int unsigned STEP_W      = 32;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned TAYLOR_TERMS = 10;

  localparam logic [AMP_W-1:0]  AMP_FULL      = 16'd32768;
  localparam logic [STEP_W-1:0] STEP_RESET    = 32'd139810;
  localparam logic [63:0]       HALF_PI_Q30   = 64'd1686629713;

  localparam int unsigned PHASE_BITS_DEF      = 32;
  localparam int unsigned TABLE_ADDR_BITS_DEF = 10;
  localparam int unsigned OUT_BITS_DEF        = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_STEP = 1'd0,
    REG_AMPLITUDE  = 1'd1
  } qtg_reg_e;

  // Table magnitudes with quadrant signs and gain, as handed to the scaler
  typedef struct packed {
    logic [ROM_W-1:0] mag_i;
    logic [ROM_W-1:0] mag_q;
    logic             neg_i;
    logic             neg_q;
    logic [AMP_W-1:0] amp;
  } qtg_sel_t;

  // Quarter-wave entry k of 2^addr_bits, Q20. Evaluated at elaboration only.
  function automatic logic [ROM_W-1:0] sine_q20(input int unsigned k,
                                                 input int unsigned addr_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    longint      one_q30;
    logic [63:0] rnd;
    one_q30 = 64'sd1 <<< 30;
    x    = (64'(k) * HALF_PI_Q30) >> addr_bits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int unsigned n = 1; n <= TAYLOR_TERMS; n++) begin
      term = (term * x2) >> 30;
      term = term / 64'((2 * n) * (2 * n + 1));
      if (n[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > one_q30) begin
      sum = one_q30;
    end
    rnd = (64'(sum) + 64'd512) >> 10;
    return rnd[ROM_W-1:0];
  endfunction

endpackage

[rtl/core/qtg_sin_rom.sv]
module qtg_sin_rom #(
  parameter int unsigned TABLE_ADDR_BITS = qtg_pkg::TABLE_ADDR_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [TABLE_ADDR_BITS:0]          addr_a_i,
  input  logic [TABLE_ADDR_BITS:0]          addr_b_i,
  output logic [qtg_pkg::ROM_W-1:0]         data_a_o,
  output logic [qtg_pkg::ROM_W-1:0]         data_b_o
);
  import qtg_pkg::*;

  localparam int unsigned DEPTH = (1 << TABLE_ADDR_BITS) + 1;

  typedef logic [ROM_W-1:0] lut_arr_t [DEPTH];

  // Entry 0 is exactly zero and the last entry exactly full scale
  function automatic lut_arr_t build_lut();
    lut_arr_t t;
    for (int unsigned k = 0; k < DEPTH; k++) begin
      if (k == 0) begin
        t[k] = '0;
      end else if (k == DEPTH - 1) begin
        t[k] = ROM_W'(1) << ROM_FRAC;
      end else begin
        t[k] = sine_q20(k, TABLE_ADDR_BITS);
      end
    end
    return t;
  endfunction

  localparam lut_arr_t SIN_LUT = build_lut();

  logic [ROM_W-1:0] data_a_q;
  logic [ROM_W-1:0] data_b_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_a_q <= SIN_LUT[addr_a_i];
      data_b_q <= SIN_LUT[addr_b_i];
    end
  end

  assign data_a_o = data_a_q;
  assign data_b_o = data_b_q;

endmodule

[rtl/core/qtg_scale.sv]
module qtg_scale #(
  parameter int unsigned OUT_BITS = qtg_pkg::OUT_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  qtg_pkg::qtg_sel_t          in_sel_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [OUT_BITS-1:0] i_sample_o,
  output logic signed [OUT_BITS-1:0] q_sample_o
);
  import qtg_pkg::*;

  localparam int unsigned PROD_W = ROM_W + AMP_W;
  localparam int unsigned OM_W   = OUT_BITS - 1;
  localparam int unsigned MUL_W  = PROD_W + OM_W;
  localparam int unsigned SHIFT  = ROM_FRAC + 15;
  localparam logic [OM_W-1:0] OUT_MAX = {OM_W{1'b1}};

  logic              mul_vld_q;
  logic [PROD_W-1:0] prod_i_q, prod_q_q;
  logic              neg_i_q, neg_q_q;
  logic              out_vld_q;
  logic [OUT_BITS-1:0] i_q, q_q;

  logic              en_mul, en_out;
  logic [MUL_W-1:0]  full_i, full_q;
  logic [OUT_BITS-1:0] mag_i, mag_q, i_d, q_d;

  // each stage loads when empty or when it drains, so bubbles collapse
  assign en_out     = !out_vld_q || out_ready_i;
  assign en_mul     = !mul_vld_q || en_out;
  assign in_ready_o = en_mul;

  assign full_i = MUL_W'(prod_i_q) * MUL_W'(OUT_MAX);
  assign full_q = MUL_W'(prod_q_q) * MUL_W'(OUT_MAX);
  assign mag_i  = full_i[SHIFT +: OUT_BITS];
  assign mag_q  = full_q[SHIFT +: OUT_BITS];
  assign i_d    = neg_i_q ? (~mag_i + OUT_BITS'(1)) : mag_i;
  assign q_d    = neg_q_q ? (~mag_q + OUT_BITS'(1)) : mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (en_mul) begin
        mul_vld_q <= in_valid_i;
      end
      if (en_out) begin
        out_vld_q <= mul_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_mul && in_valid_i) begin
      prod_i_q <= PROD_W'(in_sel_i.mag_i) * PROD_W'(in_sel_i.amp);
      prod_q_q <= PROD_W'(in_sel_i.mag_q) * PROD_W'(in_sel_i.amp);
      neg_i_q  <= in_sel_i.neg_i;
      neg_q_q  <= in_sel_i.neg_q;
    end
    if (en_out && mul_vld_q) begin
      i_q <= i_d;
      q_q <= q_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign i_sample_o  = i_q;
  assign q_sample_o  = q_q;

endmodule

[rtl/core/quadrature_tone_generator_top.sv]
// Channel   Dir  Beat fields (low bit up)
// s_axis    in   tdata: tick (bit 0), zero padding to 8 bits
// m_axis    out  tdata: i_sample, q_sample, zero padding to whole bytes
// cfg       in   cfg_idx_i 0: phase_step (32 b), 1: amplitude (16 b)
//
// One beat per clock while m_axis keeps accepting; a beat with tick high gives its
// sample through three registers (table read register, gain multiply, output scale register).
// Reset: phase 0, phase_step 139810, amplitude 32768; table is constant, no fill.
// Stalls on m_axis only back up through occupied stages; empty ones still load.
// A beat with tick low is taken but gives nothing and leaves the phase alone.
module quadrature_tone_generator_top #(
  parameter int unsigned PHASE_BITS      = qtg_pkg::PHASE_BITS_DEF,
  parameter int unsigned TABLE_ADDR_BITS = qtg_pkg::TABLE_ADDR_BITS_DEF,
  parameter int unsigned OUT_BITS        = qtg_pkg::OUT_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,  // tick
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [((2*OUT_BITS+7)/8)*8-1:0]     m_axis_tdata,  // i_sample, q_sample
  input  logic                                cfg_we_i,
  input  logic [qtg_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [qtg_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import qtg_pkg::*;

  localparam int unsigned TDATA_W = ((2 * OUT_BITS + 7) / 8) * 8;
  localparam logic [TABLE_ADDR_BITS:0] ROM_N = {1'b1, {TABLE_ADDR_BITS{1'b0}}};

  logic [STEP_W-1:0]     phase_step_q;
  logic [AMP_W-1:0]      amplitude_q;
  logic [PHASE_BITS-1:0] phase_q, phase_d;

  logic                  rd_vld_q;
  logic [1:0]            rd_quad_q;
  logic [AMP_W-1:0]      rd_amp_q;

  logic                  en_rd, take, tick;
  logic [1:0]            quad;
  logic [TABLE_ADDR_BITS:0] k_ext, k_mir, addr_s, addr_c;
  logic [AMP_W-1:0]      amp_sat;
  logic [ROM_W-1:0]      rom_s, rom_c;
  qtg_sel_t              sel;
  logic                  sc_ready;
  logic signed [OUT_BITS-1:0] i_smp, q_smp;

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= STEP_RESET;
      amplitude_q  <= AMP_FULL;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PHASE_STEP: phase_step_q <= cfg_data_i[STEP_W-1:0];
        REG_AMPLITUDE:  amplitude_q  <= cfg_data_i[AMP_W-1:0];
        default: ;
      endcase
    end
  end

  assign en_rd         = !rd_vld_q || sc_ready;
  assign s_axis_tready = en_rd;
  assign tick          = s_axis_tdata[0];
  assign take          = s_axis_tvalid && en_rd && tick;

  // quadrant in the top two phase bits, table index below them
  assign quad    = phase_q[PHASE_BITS-1 -: 2];
  assign k_ext   = {1'b0, phase_q[PHASE_BITS-3 -: TABLE_ADDR_BITS]};
  assign k_mir   = ROM_N - k_ext;
  assign addr_s  = quad[0] ? k_mir : k_ext;
  assign addr_c  = quad[0] ? k_ext : k_mir;
  assign amp_sat = (amplitude_q > AMP_FULL) ? AMP_FULL : amplitude_q;
  assign phase_d = phase_q + PHASE_BITS'(phase_step_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (take) begin
        phase_q <= phase_d;
      end
      if (en_rd) begin
        rd_vld_q <= s_axis_tvalid && tick;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      rd_quad_q <= quad;
      rd_amp_q  <= amp_sat;
    end
  end

  qtg_sin_rom #(
    .TABLE_ADDR_BITS(TABLE_ADDR_BITS)
  ) u_rom (
    .clk_i    (clk_i),
    .en_i     (take),
    .addr_a_i (addr_s),
    .addr_b_i (addr_c),
    .data_a_o (rom_s),
    .data_b_o (rom_c)
  );

  always_comb begin
    sel.mag_i = rom_c;
    sel.mag_q = rom_s;
    sel.neg_i = rd_quad_q[1] ^ rd_quad_q[0];
    sel.neg_q = rd_quad_q[1];
    sel.amp   = rd_amp_q;
  end

  qtg_scale #(
    .OUT_BITS(OUT_BITS)
  ) u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rd_vld_q),
    .in_ready_o  (sc_ready),
    .in_sel_i    (sel),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .i_sample_o  (i_smp),
    .q_sample_o  (q_smp)
  );

  assign m_axis_tdata = TDATA_W'({q_smp, i_smp});

endmodule
